// File: rtl/core/nmea_pkg.sv
package nmea_pkg;

    // Frame buffer size; a frame whose stored length reaches this is dropped
    localparam int unsigned BufferBytes = 128;

    // Character codes
    localparam logic [7:0] CH_START      = 8'h24;  // '$'
    localparam logic [7:0] CH_STAR       = 8'h2A;  // '*'
    localparam logic [7:0] CH_NINE       = 8'h39;  // '9'
    localparam logic [7:0] CH_ZERO       = 8'h30;  // '0'
    localparam logic [7:0] CH_ALPHA_BASE = 8'h37;  // 'A' - 10
    localparam logic [7:0] CH_LOWER_A    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;  // 'z'
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;
    localparam logic [7:0] BUFFER_LIMIT  = 8'(BufferBytes);

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_CSUM = 2'd2,
        KIND_LONG = 2'd3
    } kind_t;

    // Framer phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HEX1 = 4'b0100,
        PH_HEX2 = 4'b1000
    } phase_t;

    // Upper-case a character and decode it as a hex digit, unchecked
    function automatic logic [7:0] digit_value(input logic [7:0] ch);
        logic [7:0] u;
        begin
            u = ch;
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            begin
                u = ch - CASE_OFFSET;
            end
            if (u > CH_NINE)
            begin
                digit_value = u - CH_ALPHA_BASE;
            end
            else
            begin
                digit_value = u - CH_ZERO;
            end
        end
    endfunction

endpackage

// File: rtl/core/nmea_sentence_framer.sv
// NMEA 0183 sentence framer. Takes one received byte per transfer and yields
// at most one result per byte: frame bytes from '$' up to '*' (the '*' and
// the two checksum characters give no byte result), then frame good or
// checksum error with the decoded and computed sums and the frame length.
// A frame that reaches BufferBytes stored bytes ends with an overlength
// result and the framer returns to waiting for '$'. A byte is held in an input
// register and its result in an output register; one byte is taken every
// cycle while input stall is low. Input stall rises only while a result is
// held by output stall and the next byte is waiting.
module nmea_sentence_framer
    import nmea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic [7:0] received_sum,
    output logic [7:0] computed_sum,
    output logic [7:0] frame_length
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] first_hex_reg, first_hex_next;
    logic [7:0] count_reg, count_next;

    logic       out_valid_reg;
    kind_t      kind_reg, kind_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] rsum_reg, rsum_next;
    logic [7:0] csum_reg, csum_next;
    logic [7:0] len_reg, len_next;
    logic       emit_next;

    logic       advance;
    logic       out_free;
    logic [7:0] body_xor;
    logic [7:0] body_count;
    logic [7:0] first_digit;
    logic [7:0] decoded_sum;

    // Move the held byte on when the output register can take a result
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Hold the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Body and checksum arithmetic
    assign body_xor    = xor_reg ^ in_byte_reg;
    assign body_count  = (count_reg < COUNT_MAX) ? count_reg + 8'd1 : count_reg;
    assign first_digit = digit_value(first_hex_reg);
    assign decoded_sum = {first_digit[3:0], 4'b0000} + digit_value(in_byte_reg);

    // Advance the framer by one byte
    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        first_hex_next = first_hex_reg;
        count_next     = count_reg;
        emit_next      = 1'b0;
        kind_next      = KIND_BYTE;
        data_next      = 8'd0;
        rsum_next      = 8'd0;
        csum_next      = 8'd0;
        len_next       = count_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte_reg == CH_START)
                begin
                    xor_next       = 8'd0;
                    first_hex_next = 8'd0;
                    count_next     = 8'd1;
                    phase_next     = PH_BODY;
                    emit_next      = 1'b1;
                    data_next      = in_byte_reg;
                    len_next       = 8'd1;
                end
            end
            PH_BODY:
            begin
                if (in_byte_reg == CH_STAR)
                begin
                    phase_next = PH_HEX1;
                end
                else
                begin
                    xor_next   = body_xor;
                    count_next = body_count;
                    emit_next  = 1'b1;
                    len_next   = body_count;
                    if (body_count >= BUFFER_LIMIT)
                    begin
                        phase_next = PH_IDLE;
                        kind_next  = KIND_LONG;
                    end
                    else
                    begin
                        data_next = in_byte_reg;
                    end
                end
            end
            PH_HEX1:
            begin
                first_hex_next = in_byte_reg;
                phase_next     = PH_HEX2;
            end
            PH_HEX2:
            begin
                phase_next = PH_IDLE;
                emit_next  = 1'b1;
                kind_next  = (decoded_sum == xor_reg) ? KIND_GOOD : KIND_CSUM;
                rsum_next  = decoded_sum;
                csum_next  = xor_reg;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Framer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            xor_reg       <= 8'd0;
            first_hex_reg <= 8'd0;
            count_reg     <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            first_hex_reg <= first_hex_next;
            count_reg     <= count_next;
        end
    end

    // Result register: load on a result, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_next)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            rsum_reg <= rsum_next;
            csum_reg <= csum_next;
            len_reg  <= len_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign data         = data_reg;
    assign received_sum = rsum_reg;
    assign computed_sum = csum_reg;
    assign frame_length = len_reg;

endmodule
